/* design/wbps_pkg.sv */
// Shared constants and types for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int POSITION_BITS     = 32;
	localparam int ADDR_BITS         = 32;
	localparam int CFG_DATA_BITS     = 64;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int WIN_IDX_BITS      = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int HOLD_BITS         = 4;

	localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_SEARCH_MODE    = 3'd3,
		REG_REGION_BASE    = 3'd4
	} cfg_reg_t;

	typedef logic [MAX_PATTERN_BYTES-1:0][7:0] byte_window_t;
	typedef logic [15:0][7:0] pattern_t;

	typedef struct packed {
		logic                     hit;
		logic [POSITION_BITS-1:0] start;
	} match_res_t;

endpackage

/* design/wbps_compare.sv */
// Window against pattern compare, inside-region and hold-off qualification.
`timescale 1ns / 1ps

module wbps_compare (
	input  wbps_pkg::byte_window_t             window,
	input  wbps_pkg::pattern_t                 pattern,
	input  logic [wbps_pkg::LEN_BITS-1:0]      length,
	input  logic                               exact,
	input  logic [wbps_pkg::POSITION_BITS-1:0] position,
	input  logic [wbps_pkg::HOLD_BITS-1:0]     holdoff,
	output wbps_pkg::match_res_t               result
);

	logic [wbps_pkg::WIN_IDX_BITS-1:0]  lm1;
	logic [wbps_pkg::MAX_PATTERN_BYTES-1:0] byte_ok;
	logic                               in_region;

	assign lm1 = wbps_pkg::WIN_IDX_BITS'(length - wbps_pkg::LEN_BITS'(1));

	// pattern byte k lines up with window entry length-1-k
	always_comb begin
		for (int k = 0; k < wbps_pkg::MAX_PATTERN_BYTES; k++) begin
			logic [wbps_pkg::WIN_IDX_BITS-1:0] idx;
			logic [7:0] pb;
			idx = lm1 - wbps_pkg::WIN_IDX_BITS'(k);
			pb = pattern[k];
			byte_ok[k] = (wbps_pkg::WIN_IDX_BITS'(k) > lm1)
				|| (!exact && pb == wbps_pkg::WILDCARD_BYTE)
				|| (pb == window[idx]);
		end
	end

	assign in_region = position >= wbps_pkg::POSITION_BITS'(lm1);

	assign result.hit   = (holdoff == '0) && in_region && (&byte_ok);
	assign result.start = position - wbps_pkg::POSITION_BITS'(lm1);

endmodule

/* design/wbps_out_reg.sv */
// Result register holding one match address until the receiver takes it.
`timescale 1ns / 1ps

module wbps_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [wbps_pkg::ADDR_BITS-1:0] load_address,
	output logic                           busy,
	output logic                           match_valid,
	input  logic                           match_ready,
	output logic [wbps_pkg::ADDR_BITS-1:0] match_address
);

	logic                           valid_q;
	logic [wbps_pkg::ADDR_BITS-1:0] address_q;

	// blocked while a word sits here and the receiver stalls
	assign busy = valid_q && !match_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (match_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			address_q <= load_address;
		end
	end

	assign match_valid   = valid_q;
	assign match_address = address_q;

endmodule

/* design/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner.
//
// Feed the bytes of a memory region on data_byte, one word per handshake on
// data_valid/data_ready, with end_of_region high on the region's last byte.
// Each match of the configured pattern (1 to 16 bytes, 0x3F a wildcard unless
// search_mode is 1) that lies wholly inside the region gives one word on
// match_valid/match_ready: region_base plus the offset of its first byte.
// Matches never overlap. Bytes that complete no match give nothing.
// match_valid rises as the match's last byte moves from the input stage register
// to the result register. Throughput: one byte per cycle while not stalled;
// the window shift loads the input stage register, and the 16-byte compare sits
// between it and the result register. When the receiver stalls, the result
// register holds its word; the input stage keeps taking bytes until it holds a
// byte that matches, then data_ready drops until the result register frees.
// Reset clears the registers to pattern length 1, wildcard mode, base 0, the
// byte position and hold-off to zero, and empties both stages. The byte
// window is not cleared. Write configuration through cfg_write_en, cfg_index
// and cfg_data only while no bytes are in flight.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                data_valid,
	output logic                                data_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                end_of_region,
	output logic                                match_valid,
	input  logic                                match_ready,
	output logic [wbps_pkg::ADDR_BITS-1:0]      match_address
);

	logic [63:0]                      pattern_low_q;
	logic [63:0]                      pattern_high_q;
	logic [4:0]                       pattern_length_q;
	logic                             search_mode_q;
	logic [wbps_pkg::ADDR_BITS-1:0]   region_base_q;

	wbps_pkg::byte_window_t           byte_window_q;
	logic [wbps_pkg::POSITION_BITS-1:0] position_q;
	logic [wbps_pkg::HOLD_BITS-1:0]   holdoff_q;

	logic                             valid_s1;
	logic                             last_s1;
	logic [wbps_pkg::POSITION_BITS-1:0] position_s1;

	logic [wbps_pkg::LEN_BITS-1:0]    len_eff;
	wbps_pkg::match_res_t             res;
	logic                             out_busy;
	logic                             s1_go;
	logic                             accept;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= 5'd1;
			search_mode_q    <= 1'b0;
			region_base_q    <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				wbps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				wbps_pkg::REG_SEARCH_MODE:    search_mode_q    <= cfg_data[0];
				wbps_pkg::REG_REGION_BASE:    region_base_q    <= cfg_data[wbps_pkg::ADDR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamp the length into 1..MAX_PATTERN_BYTES
	always_comb begin
		if (pattern_length_q == '0) begin
			len_eff = wbps_pkg::LEN_BITS'(1);
		end else if (32'(pattern_length_q) > wbps_pkg::MAX_PATTERN_BYTES) begin
			len_eff = wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN_BYTES);
		end else begin
			len_eff = wbps_pkg::LEN_BITS'(pattern_length_q);
		end
	end

	// stage 1 retires when it has no match or the result register can take one
	assign s1_go      = valid_s1 && (!res.hit || !out_busy);
	assign data_ready = !valid_s1 || s1_go;
	assign accept     = data_valid && data_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			position_q <= '0;
		end else begin
			if (accept) begin
				valid_s1   <= 1'b1;
				position_q <= end_of_region ? '0
					: position_q + wbps_pkg::POSITION_BITS'(1);
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_window_q <= {byte_window_q[wbps_pkg::MAX_PATTERN_BYTES-2:0], data_byte};
			last_s1       <= end_of_region;
			position_s1   <= position_q;
		end
	end

	// hold-off advances as each byte leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				holdoff_q <= '0;
			end else if (holdoff_q != '0) begin
				holdoff_q <= holdoff_q - wbps_pkg::HOLD_BITS'(1);
			end else if (res.hit) begin
				holdoff_q <= wbps_pkg::HOLD_BITS'(len_eff - wbps_pkg::LEN_BITS'(1));
			end
		end
	end

	wbps_compare u_compare (
		.window   (byte_window_q),
		.pattern  ({pattern_high_q, pattern_low_q}),
		.length   (len_eff),
		.exact    (search_mode_q),
		.position (position_s1),
		.holdoff  (holdoff_q),
		.result   (res)
	);

	wbps_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_go && res.hit),
		.load_address  (region_base_q + wbps_pkg::ADDR_BITS'(res.start)),
		.busy          (out_busy),
		.match_valid   (match_valid),
		.match_ready   (match_ready),
		.match_address (match_address)
	);

`ifndef SYNTHESIS
	a_holdoff_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && res.hit && !last_s1 |=> holdoff_q ==
			$past(wbps_pkg::HOLD_BITS'(len_eff - wbps_pkg::LEN_BITS'(1))))
		else $error("hold-off not loaded after a match");

	a_no_hit_in_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && holdoff_q != '0 |-> !res.hit)
		else $error("match reported during hold-off");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |-> match_valid && !match_ready)
		else $error("stage 1 stalled with a free result register");

	a_region_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_region |=> position_q == '0)
		else $error("byte position not cleared at region end");

	a_last_clears_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> holdoff_q == '0)
		else $error("hold-off not cleared at region end");
`endif

endmodule
